FILE: hdl/sik_pkg.sv
// shared types, constants and step functions of the swerve drive kinematics block
package sik_pkg;

  localparam int NW = 4;            // wheels
  localparam int SQ_STEPS = 16;     // root bits of a 32-bit radicand
  localparam int DIV_STEPS = 15;    // quotient bits of the limit scaling
  localparam int CORDIC_STEPS = 16;
  localparam int VEC_W = 18;        // wheel vector component
  localparam int CW = 34;           // cordic x/y datapath
  localparam int ZW = 24;           // cordic angle accumulator
  localparam int PRESHIFT = 14;

  localparam logic signed [ZW-1:0] QUARTER_TURN = 24'sd1474560;
  localparam logic signed [14:0] ANG_HALF = 15'sd11520;
  localparam logic signed [14:0] ANG_QUARTER = 15'sd5760;
  localparam logic signed [16:0] ANG_HALF_W = 17'sd11520;
  localparam logic signed [16:0] ANG_FULL_W = 17'sd23040;

  // atan(2^-i) in 1/16384 degree
  localparam logic [20:0] ATAN_TAB [CORDIC_STEPS] = '{
    21'd737280, 21'd435242, 21'd229970, 21'd116736, 21'd58595, 21'd29326,
    21'd14667, 21'd7334, 21'd3667, 21'd1833, 21'd917, 21'd458, 21'd229,
    21'd115, 21'd57, 21'd29
  };

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    logic [18:0] rem;
    logic [15:0] res;
    logic [31:0] rad;
  } sqrt_t;

  // one digit of the bitwise square root, two radicand bits per step
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t o;
    logic [18:0] acc;
    logic [18:0] trial;
    acc = {s.rem[16:0], s.rad[31:30]};
    trial = {1'b0, s.res, 2'b01};
    o.rad = {s.rad[29:0], 2'b00};
    if (acc >= trial) begin
      o.rem = acc - trial;
      o.res = {s.res[14:0], 1'b1};
    end else begin
      o.rem = acc;
      o.res = {s.res[14:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: hdl/sik_wheel.sv
// per-wheel pipeline: speed square root and cordic steering angle for four lanes
module sik_wheel
  import sik_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  vec_t        wx [NW],
  input  vec_t        wy [NW],
  input  logic [14:0] speed_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] speed [NW],
  output logic [14:0] angle [NW]
);

  localparam int NS = CORDIC_STEPS + 2;

  typedef struct packed {
    sqrt_t       s;
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [ZW-1:0] z;
    logic        x0;
    logic        y0;
    logic        xpos;
    logic        yneg;
  } lane_t;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  lane_t st [NS-1][NW];
  lane_t nx [NS-1][NW];
  logic [14:0] spd_nx [NW];
  logic signed [14:0] ang_nx [NW];

  assign en[NS-1] = ~v[NS-1] | out_ready;
  for (genvar j = 0; j < NS - 1; j++) begin : g_en
    assign en[j] = ~v[j] | en[j+1];
  end
  assign in_ready = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int j = 1; j < NS; j++) begin
        if (en[j]) v[j] <= v[j-1];
      end
    end
  end

  for (genvar l = 0; l < NW; l++) begin : g_lane
    // entry: squares and quarter-turn pre-rotation into the right half plane
    always_comb begin
      logic [VEC_W-1:0] axw;
      logic [VEC_W-1:0] ayw;
      logic [31:0] xsq;
      logic [31:0] ysq;
      logic [32:0] sum;
      logic signed [CW-1:0] ya;
      logic signed [CW-1:0] xb;
      axw = wx[l][VEC_W-1] ? VEC_W'(-wx[l]) : VEC_W'(wx[l]);
      ayw = wy[l][VEC_W-1] ? VEC_W'(-wy[l]) : VEC_W'(wy[l]);
      xsq = axw[15:0] * axw[15:0];
      ysq = ayw[15:0] * ayw[15:0];
      sum = {1'b0, xsq} + {1'b0, ysq};
      ya = CW'(wy[l]) <<< PRESHIFT;
      xb = CW'(wx[l]) <<< PRESHIFT;
      nx[0][l].s = '{rem: '0, res: '0, rad: sum[31:0]};
      nx[0][l].x0 = (wx[l] == '0);
      nx[0][l].y0 = (wy[l] == '0);
      nx[0][l].xpos = (wx[l] > 0);
      nx[0][l].yneg = wy[l][VEC_W-1];
      if (ya < 0) begin
        if (xb >= 0) begin
          nx[0][l].a = xb;
          nx[0][l].b = -ya;
          nx[0][l].z = QUARTER_TURN;
        end else begin
          nx[0][l].a = -xb;
          nx[0][l].b = ya;
          nx[0][l].z = -QUARTER_TURN;
        end
      end else begin
        nx[0][l].a = ya;
        nx[0][l].b = xb;
        nx[0][l].z = '0;
      end
    end

    for (genvar j = 1; j < NS - 1; j++) begin : g_step
      localparam int I = j - 1;
      localparam logic signed [CW-1:0] BIAS = CW'((64'd1 << I) - 64'd1);
      always_comb begin
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] ab;
        logic signed [CW-1:0] bb;
        logic signed [CW-1:0] da;
        logic signed [CW-1:0] db;
        logic signed [ZW-1:0] z;
        nx[j][l] = st[j-1][l];
        nx[j][l].s = sqrt_step(st[j-1][l].s);
        a = $signed(st[j-1][l].a);
        b = $signed(st[j-1][l].b);
        z = $signed(st[j-1][l].z);
        // shifts truncate toward zero
        bb = b;
        ab = a;
        if (b < 0) bb = b + BIAS;
        if (a < 0) ab = a + BIAS;
        da = bb >>> I;
        db = ab >>> I;
        if (b > 0) begin
          nx[j][l].a = a + da;
          nx[j][l].b = b - db;
          nx[j][l].z = z + $signed(ZW'(ATAN_TAB[I]));
        end else begin
          nx[j][l].a = a - da;
          nx[j][l].b = b + db;
          nx[j][l].z = z - $signed(ZW'(ATAN_TAB[I]));
        end
      end
    end

    for (genvar j = 0; j < NS - 1; j++) begin : g_reg
      always_ff @(posedge clk) begin
        if (en[j]) st[j][l] <= nx[j][l];
      end
    end

    // output: round the angle to 1/64 degree, wrap, clamp the speed
    always_comb begin
      lane_t f;
      logic signed [ZW-1:0] z;
      logic [ZW-1:0] zm;
      logic [ZW-1:0] zsum;
      logic [15:0] qm;
      logic signed [16:0] qs;
      f = st[NS-2][l];
      z = $signed(f.z);
      zm = (z < 0) ? ZW'(-z) : ZW'(z);
      zsum = zm + ZW'(128);
      qm = zsum[ZW-1:8];
      qs = (z < 0) ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      if (qs <= -ANG_HALF_W) qs = qs + ANG_FULL_W;
      else if (qs > ANG_HALF_W) qs = qs - ANG_FULL_W;
      if (f.x0) begin
        ang_nx[l] = f.yneg ? ANG_HALF : '0;
      end else if (f.y0) begin
        ang_nx[l] = f.xpos ? ANG_QUARTER : -ANG_QUARTER;
      end else begin
        ang_nx[l] = qs[14:0];
      end
      spd_nx[l] = (f.s.res > {1'b0, speed_limit}) ? speed_limit : f.s.res[14:0];
    end

    always_ff @(posedge clk) begin
      if (en[NS-1]) begin
        speed[l] <= spd_nx[l];
        angle[l] <= ang_nx[l];
      end
    end
  end

`ifndef SYNTHESIS
  a_speed_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed[0] <= speed_limit && speed[1] <= speed_limit &&
                   speed[2] <= speed_limit && speed[3] <= speed_limit))
    else $error("wheel speed above limit");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(angle[0]) > -ANG_HALF && $signed(angle[1]) > -ANG_HALF &&
                   $signed(angle[2]) > -ANG_HALF && $signed(angle[3]) > -ANG_HALF &&
                   $signed(angle[0]) <= ANG_HALF && $signed(angle[1]) <= ANG_HALF &&
                   $signed(angle[2]) <= ANG_HALF && $signed(angle[3]) <= ANG_HALF))
    else $error("steering angle out of range");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !v[NS-1] |-> in_ready)
    else $error("pipeline with empty output stage refused a request");
`endif

endmodule

FILE: hdl/swerve_drive_inverse_kinematics_top.sv
// top level: config registers, xy speed limiting, rotation term and wheel pipeline
//
// Four-wheel swerve inverse kinematics. One request on the s_axis stream carries
// a chassis command (vel_x, vel_y, turn_rate); one request on the m_axis stream
// returns the speed and steering angle of every wheel. The user must set
// wheel_offset and speed_limit over the APB port only while no request is in
// flight; the block does not enforce this. The datapath is a single pipeline
// with a valid bit per stage: products and limit test (2 stages), a 16-stage
// square root of the xy magnitude, a 15-stage divider that rescales vel_x/vel_y
// onto the limit, then per wheel a square root and 16 cordic steps side by side
// plus a rounding stage (18). One request is taken every cycle unless stalled.
// Each stage advances when it is empty or its successor advances, so when
// m_axis_tready is low the results hold in the output stage while upstream
// bubbles still fill and s_axis_tready drops only once the pipeline is full.
// Reset clears all valid bits and loads wheel_offset 4096 and speed_limit 768.
module swerve_drive_inverse_kinematics_top
  import sik_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // vel_x, vel_y, turn_rate
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // speed_front_left, speed_rear_left, speed_front_right, speed_rear_right,
  // angle_front_left, angle_rear_left, angle_front_right, angle_rear_right
  output logic [119:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic REG_WHEEL_OFFSET = 1'b0;
  localparam logic REG_SPEED_LIMIT = 1'b1;
  localparam int NF = 2 + SQ_STEPS + DIV_STEPS;
  localparam int QB = 2;
  localparam int DB = 2 + SQ_STEPS;

  typedef struct packed {
    sqrt_t       s;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [29:0] numx;
    logic [29:0] numy;
    logic [14:0] r;
    logic        over;
  } fq_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] rest;
    logic [14:0] q;
  } div_t;

  typedef struct packed {
    div_t        dx;
    div_t        dy;
    logic [15:0] den;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [14:0] r;
    logic        over;
  } fd_t;

  function automatic div_t div_step(input div_t d, input logic [15:0] den);
    div_t o;
    logic [16:0] t;
    t = {d.rem, d.rest[14]};
    o.rest = {d.rest[13:0], 1'b0};
    if (t >= {1'b0, den}) begin
      o.rem = 16'(t - {1'b0, den});
      o.q = {d.q[13:0], 1'b1};
    end else begin
      o.rem = t[15:0];
      o.q = {d.q[13:0], 1'b0};
    end
    return o;
  endfunction

  // configuration
  logic [15:0] wheel_offset;
  logic [14:0] speed_limit;
  logic [29:0] lim_sq;
  logic        cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_offset <= 16'd4096;
      speed_limit <= 15'd768;
      lim_sq <= 30'd589824;
    end else begin
      lim_sq <= speed_limit * speed_limit;
      if (cfg_write) begin
        unique case (paddr[2])
          REG_WHEEL_OFFSET: wheel_offset <= pwdata[15:0];
          REG_SPEED_LIMIT:  speed_limit <= pwdata[14:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WHEEL_OFFSET: prdata = {16'b0, wheel_offset};
      REG_SPEED_LIMIT:  prdata = {17'b0, speed_limit};
      default:          prdata = '0;
    endcase
  end

  // stage control
  logic [NF-1:0] fv;
  logic [NF-1:0] fen;
  logic          w_ready;

  assign fen[NF-1] = ~fv[NF-1] | w_ready;
  for (genvar i = 0; i < NF - 1; i++) begin : g_en
    assign fen[i] = ~fv[i] | fen[i+1];
  end
  assign s_axis_tready = fen[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      if (fen[0]) fv[0] <= s_axis_tvalid;
      for (int i = 1; i < NF; i++) begin
        if (fen[i]) fv[i] <= fv[i-1];
      end
    end
  end

  // stage 0: squares, scaling numerators, rotation product
  logic signed [15:0] in_vx;
  logic signed [15:0] in_vy;
  logic signed [15:0] in_tr;
  logic [15:0] ax;
  logic [15:0] ay;
  logic [31:0] ax_sq;
  logic [31:0] ay_sq;
  logic [32:0] sq_sum;
  logic [30:0] numx_w;
  logic [30:0] numy_w;
  logic signed [32:0] p_w;

  assign in_vx = s_axis_tdata[15:0];
  assign in_vy = s_axis_tdata[31:16];
  assign in_tr = s_axis_tdata[47:32];
  assign ax = in_vx[15] ? 16'(-in_vx) : in_vx;
  assign ay = in_vy[15] ? 16'(-in_vy) : in_vy;
  assign ax_sq = ax * ax;
  assign ay_sq = ay * ay;
  assign sq_sum = {1'b0, ax_sq} + {1'b0, ay_sq};
  assign numx_w = ax * speed_limit;
  assign numy_w = ay * speed_limit;
  assign p_w = in_tr * $signed({1'b0, wheel_offset});

  logic [15:0] s0_vx;
  logic [15:0] s0_vy;
  logic [31:0] s0_sq;
  logic [29:0] s0_numx;
  logic [29:0] s0_numy;
  logic signed [32:0] s0_p;

  always_ff @(posedge clk) begin
    if (fen[0]) begin
      s0_vx <= in_vx;
      s0_vy <= in_vy;
      s0_sq <= sq_sum[31:0];
      s0_numx <= numx_w[29:0];
      s0_numy <= numy_w[29:0];
      s0_p <= p_w;
    end
  end

  // stage 1: limit test and rounded rotation term
  logic [32:0] pm;
  logic [31:0] r_sum;
  logic [13:0] rm;
  fq_t s1;

  assign pm = s0_p[32] ? 33'(-s0_p) : 33'(s0_p);
  assign r_sum = pm[31:0] + 32'd131072;
  assign rm = r_sum[31:18];

  always_ff @(posedge clk) begin
    if (fen[1]) begin
      s1.s <= '{rem: '0, res: '0, rad: s0_sq};
      s1.vx <= s0_vx;
      s1.vy <= s0_vy;
      s1.numx <= s0_numx;
      s1.numy <= s0_numy;
      s1.r <= s0_p[32] ? 15'(-$signed({1'b0, rm})) : {1'b0, rm};
      s1.over <= (s0_sq > {2'b0, lim_sq});
    end
  end

  // xy magnitude square root
  fq_t q_st [SQ_STEPS];
  fq_t q_nx [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    if (k == 0) begin : g_first
      always_comb begin
        q_nx[k] = s1;
        q_nx[k].s = sqrt_step(s1.s);
      end
    end else begin : g_next
      always_comb begin
        q_nx[k] = q_st[k-1];
        q_nx[k].s = sqrt_step(q_st[k-1].s);
      end
    end
    always_ff @(posedge clk) begin
      if (fen[QB+k]) q_st[k] <= q_nx[k];
    end
  end

  // rescale |v| * limit / magnitude, one quotient bit per stage
  fd_t d_st [DIV_STEPS];
  fd_t d_nx [DIV_STEPS];
  fd_t d_first;
  fq_t qe;

  assign qe = q_st[SQ_STEPS-1];

  always_comb begin
    d_first.dx = '{rem: {1'b0, qe.numx[29:15]}, rest: qe.numx[14:0], q: '0};
    d_first.dy = '{rem: {1'b0, qe.numy[29:15]}, rest: qe.numy[14:0], q: '0};
    d_first.den = qe.s.res;
    d_first.vx = qe.vx;
    d_first.vy = qe.vy;
    d_first.r = qe.r;
    d_first.over = qe.over;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    if (k == 0) begin : g_first
      always_comb begin
        d_nx[k] = d_first;
        d_nx[k].dx = div_step(d_first.dx, d_first.den);
        d_nx[k].dy = div_step(d_first.dy, d_first.den);
      end
    end else begin : g_next
      always_comb begin
        d_nx[k] = d_st[k-1];
        d_nx[k].dx = div_step(d_st[k-1].dx, d_st[k-1].den);
        d_nx[k].dy = div_step(d_st[k-1].dy, d_st[k-1].den);
      end
    end
    always_ff @(posedge clk) begin
      if (fen[DB+k]) d_st[k] <= d_nx[k];
    end
  end

  // wheel vectors
  fd_t de;
  logic signed [16:0] vxs;
  logic signed [16:0] vys;
  logic signed [14:0] rr;
  vec_t wx [NW];
  vec_t wy [NW];

  assign de = d_st[DIV_STEPS-1];
  assign rr = $signed(de.r);

  always_comb begin
    if (de.over) begin
      vxs = de.vx[15] ? -$signed({2'b0, de.dx.q}) : $signed({2'b0, de.dx.q});
      vys = de.vy[15] ? -$signed({2'b0, de.dy.q}) : $signed({2'b0, de.dy.q});
    end else begin
      vxs = 17'($signed(de.vx));
      vys = 17'($signed(de.vy));
    end
    wx[0] = VEC_W'(vxs) - VEC_W'(rr);
    wy[0] = VEC_W'(vys) - VEC_W'(rr);
    wx[1] = VEC_W'(vxs) + VEC_W'(rr);
    wy[1] = VEC_W'(vys) - VEC_W'(rr);
    wx[2] = VEC_W'(vxs) - VEC_W'(rr);
    wy[2] = VEC_W'(vys) + VEC_W'(rr);
    wx[3] = VEC_W'(vxs) + VEC_W'(rr);
    wy[3] = VEC_W'(vys) + VEC_W'(rr);
  end

  logic [14:0] speed [NW];
  logic [14:0] angle [NW];

  sik_wheel u_wheel (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (fv[NF-1]),
    .in_ready    (w_ready),
    .wx          (wx),
    .wy          (wy),
    .speed_limit (speed_limit),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .speed       (speed),
    .angle       (angle)
  );

  assign m_axis_tdata = {angle[3], angle[2], angle[1], angle[0],
                         speed[3], speed[2], speed[1], speed[0]};

`ifndef SYNTHESIS
  a_front_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !fv[0] |-> s_axis_tready)
    else $error("empty first stage refused a request");

  a_limit_zero_no_scale: assert property (@(posedge clk) disable iff (rst)
    (fv[1] && s1.s.rad == '0) |-> !s1.over)
    else $error("zero command flagged over the limit");

  a_scaled_within_limit: assert property (@(posedge clk) disable iff (rst)
    (fv[NF-1] && de.over) |-> (de.dx.q <= speed_limit && de.dy.q <= speed_limit))
    else $error("scaled component above the limit");
`endif

endmodule

FILE: test/tb_swerve_drive_inverse_kinematics_top.sv
// testbench for the swerve drive inverse kinematics block: predicted wheel speeds and angles
module tb_swerve_drive_inverse_kinematics_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sik_pkg::*;

  localparam logic [2:0] ADDR_WHEEL_OFFSET = 3'd0;
  localparam logic [2:0] ADDR_SPEED_LIMIT = 3'd4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [14:0] ang_rr, ang_fr, ang_rl, ang_fl;
    logic [14:0] spd_rr, spd_fr, spd_rl, spd_fl;
  } wheels_t;

  class wheel_scoreboard;
    logic [15:0] offset_q;
    logic [14:0] limit_q;
    wheels_t pending[$];
    int errors;
    int commands;
    int results;

    function new();
      offset_q = 16'd4096;
      limit_q = 15'd768;
      errors = 0;
      commands = 0;
      results = 0;
    endfunction

    function longint root_floor(longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function longint trunc_shift(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
    endfunction

    function longint heading(longint x, longint y);
      longint a, b, t, z, q, da, db;
      longint atans[16];
      atans = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                3667, 1833, 917, 458, 229, 115, 57, 29};
      if (x == 0) return (y < 0) ? 11520 : 0;
      if (y == 0) return (x > 0) ? 5760 : -5760;
      a = y * 16384;
      b = x * 16384;
      z = 0;
      if (a < 0) begin
        if (b >= 0) begin
          t = a; a = b; b = -t; z = 1474560;
        end else begin
          t = a; a = -b; b = t; z = -1474560;
        end
      end
      for (int i = 0; i < 16; i++) begin
        da = trunc_shift(b, i);
        db = trunc_shift(a, i);
        if (b > 0) begin
          a += da; b -= db; z += atans[i];
        end else begin
          a -= da; b += db; z -= atans[i];
        end
      end
      if (z < 0) q = -(((-z) + 128) >>> 8);
      else q = (z + 128) >>> 8;
      if (q <= -11520) q += 23040;
      if (q > 11520) q -= 23040;
      return q;
    endfunction

    function void note_command(logic [47:0] cmd);
      longint vx, vy, tr, lim, sq, m, p, r, wx, wy, spd;
      longint spds[4], angs[4];
      wheels_t w;
      vx = longint'($signed(cmd[15:0]));
      vy = longint'($signed(cmd[31:16]));
      tr = longint'($signed(cmd[47:32]));
      lim = longint'(limit_q);
      sq = vx * vx + vy * vy;
      if (sq > lim * lim) begin
        m = root_floor(sq);
        vx = (vx < 0) ? -(((-vx) * lim) / m) : (vx * lim) / m;
        vy = (vy < 0) ? -(((-vy) * lim) / m) : (vy * lim) / m;
      end
      p = tr * longint'(offset_q);
      r = (((p < 0) ? -p : p) + (64'sd1 <<< 17)) >>> 18;
      if (p < 0) r = -r;
      for (int k = 0; k < 4; k++) begin
        // front left, rear left, front right, rear right
        wx = vx + ((k % 2 == 0) ? -r : r);
        wy = vy + ((k < 2) ? -r : r);
        spd = root_floor(wx * wx + wy * wy);
        if (spd > lim) spd = lim;
        spds[k] = spd;
        angs[k] = heading(wx, wy);
      end
      w.spd_fl = spds[0][14:0]; w.spd_rl = spds[1][14:0];
      w.spd_fr = spds[2][14:0]; w.spd_rr = spds[3][14:0];
      w.ang_fl = angs[0][14:0]; w.ang_rl = angs[1][14:0];
      w.ang_fr = angs[2][14:0]; w.ang_rr = angs[3][14:0];
      pending.push_back(w);
      commands++;
    endfunction

    function void check_result(logic [119:0] data);
      wheels_t got, exp;
      logic [14:0] g, e;
      results++;
      got = data;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp = pending.pop_front();
      for (int f = 0; f < 8; f++) begin
        g = 15'(got >> (15 * f));
        e = 15'(exp >> (15 * f));
        if (g !== e) begin
          $display("%0t: field %0d expected %0d actual %0d", $time, f, e, g);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // vel_x, vel_y, turn_rate
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [119:0] m_axis_tdata;       // speeds fl, rl, fr, rr, then angles fl, rl, fr, rr
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wheel_scoreboard sb;
  bit stall_long = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  swerve_drive_inverse_kinematics_top dut (.*);

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_WHEEL_OFFSET) sb.offset_q = value[15:0];
    else if (addr == ADDR_SPEED_LIMIT) sb.limit_q = value[14:0];
  endtask

  task automatic send_command(input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] tr, input bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 7) : 0;
    repeat (wait_n) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {tr, vy, vx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command({tr, vy, vx});
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_vel();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1600)) - 800);
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      3: return {16{$urandom_range(0, 1) == 1}} ^ 16'($urandom_range(0, 3));
      default: return 16'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // receiver: check every accepted result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    int n;
    m_axis_tready <= 0;
    @(negedge rst);
    forever begin
      if (stall_long) begin
        m_axis_tready <= 0;
        repeat (120) @(posedge clk);
        stall_long = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
      if (n != 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] edge_vals[6];
    logic [15:0] offs[4];
    logic [14:0] lims[4];
    sb = new();
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0100};
    offs = '{16'd0, 16'hffff, 16'd4096, 16'd9000};
    lims = '{15'd0, 15'h7fff, 15'd768, 15'd2000};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: axes, zero vector, extremes, limit scaling
    send_command(16'd0, 16'd0, 16'd0, 0);
    send_command(16'd0, 16'd100, 16'd0, 0);
    send_command(16'd0, -16'sd100, 16'd0, 0);
    send_command(16'd100, 16'd0, 16'd0, 0);
    send_command(-16'sd100, 16'd0, 16'd0, 0);
    send_command(16'd0, 16'd0, 16'd4096, 0);
    send_command(16'd300, 16'd400, 16'd0, 1);
    for (int i = 0; i < 6; i++)
      send_command(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6], 1);
    send_command(16'h8000, 16'h8000, 16'h8000, 0);
    send_command(16'h7fff, 16'h7fff, 16'h7fff, 0);
    s_axis_tvalid <= 0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      reg_write(ADDR_WHEEL_OFFSET, (ph < 4) ? {16'hdead, offs[ph]} : $urandom);
      reg_write(ADDR_SPEED_LIMIT, (ph < 4) ? {17'h1abcd, lims[ph]} : $urandom);
      if (ph == 0) begin
        send_command(16'd500, 16'd0, 16'h1000, 0);
        send_command(16'hffff, 16'h8000, 16'h7fff, 0);
      end
      if (ph == 2) stall_long = 1;
      for (int i = 0; i < 275; i++)
        send_command(pick_vel(), pick_vel(), pick_vel(), (ph != 2) && (i % 60 > 10));
      s_axis_tvalid <= 0;
      drain();
    end

    $display("sent %0d commands, checked %0d results over 5 register settings",
             sb.commands, sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
